### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      ge;
    } t_link;

endpackage

### src/spq_cell.sv
// One storage cell of the sorted shift chain.
module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_occ,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_link                     i_prev,
    input  t_link                     i_next,
    output t_link                     o_link
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      ge;

    assign ge = i_occ && (r_value >= i_value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.push && !ge) begin
            n_value = i_prev.ge ? i_value : i_prev.value;
        end else if (i_ctl.pop) begin
            n_value = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.ge    = ge;

endmodule

### src/sorted_priority_queue.sv
// Top level: sorted priority queue built from a chain of shifting cells.
//
// Holds up to DEPTH signed 32-bit values, largest first; equal values leave in
// arrival order. One item is taken every clock cycle (busy stays low), and its
// result is registered and appears with o_done in the cycle after acceptance:
// every cell compares the incoming value against its own entry and shifts in
// parallel, whatever the fill level. Results cannot be stalled; sample them on
// the o_done cycle. A pop on an empty queue reports status 1, a push on a full
// queue is dropped with status 2.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_done,
    output logic signed [VALUE_W-1:0] o_popped_value,
    output logic [1:0]                o_status,
    output logic [ENTRY_W-1:0]        o_entry_count,
    output logic                      o_is_empty
);

    logic              accept;
    logic              is_full;
    logic              is_empty;
    t_cell_ctl         ctl;
    logic [DEPTH-1:0]  occ;
    t_link             links [DEPTH];
    t_link             head_link;
    t_link             tail_link;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           status;
    logic              r_done;
    logic signed [VALUE_W-1:0] r_popped;
    t_status           r_status;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    assign ctl.push = accept && (t_op'(i_op) == OP_PUSH) && !is_full;
    assign ctl.pop  = accept && (t_op'(i_op) == OP_POP) && !is_empty;

    assign head_link.value = '0;
    assign head_link.ge    = 1'b1;
    assign tail_link.value = '0;
    assign tail_link.ge    = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign occ[gi] = (CNT_W'(gi) < r_count);
            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_occ   (occ[gi]),
                .i_value (i_value),
                .i_prev  ((gi == 0) ? head_link : links[(gi == 0) ? 0 : gi - 1]),
                .i_next  ((gi == DEPTH - 1) ? tail_link
                                            : links[(gi == DEPTH - 1) ? gi : gi + 1]),
                .o_link  (links[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        status  = ST_OK;
        if (ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (ctl.pop) begin
            n_count = r_count - 1'b1;
        end
        if (accept && (t_op'(i_op) == OP_PUSH) && is_full) begin
            status = ST_FULL;
        end else if (accept && (t_op'(i_op) == OP_POP) && is_empty) begin
            status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= ctl.pop ? links[0].value : '0;
        r_status <= status;
    end

    assign o_done         = r_done;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = ENTRY_W'(r_count);
    assign o_is_empty     = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drop one entry");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !ctl.push && !ctl.pop) |=> (r_count == $past(r_count)))
        else $error("rejected item changed the count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_popped_value == '0))
        else $error("error result carries a value");

endmodule
